// ----- rtl/core/sgca_pkg.sv -----
// ----------------------------------------------------------------------------
// sgca_pkg
// Shared widths and stage payload types of the segment closest-approach pipe.
// ----------------------------------------------------------------------------
package sgca_pkg;

	localparam int CW       = 16;            // coordinate width
	localparam int DW       = CW + 1;        // edge vector component
	localparam int PW       = 2 * DW + 2;    // dot product
	localparam int XW       = 2 * PW;        // determinant and numerators
	localparam int FW       = XW - 2;        // clamped fraction terms
	localparam int QW       = DW;            // scaled quotient
	localparam int LW       = 16;            // parallel limit register
	localparam int LANES    = 6;             // near point coordinates
	localparam int NPTS     = 12;            // input coordinates
	localparam int GW       = 17;            // gap length
	localparam int SW       = 2 * GW;        // squared gap
	localparam int IN_W     = NPTS * CW;
	localparam int OUT_BITS = GW + LANES * CW;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [2:0][CW-1:0] pa;
		logic [2:0][CW-1:0] pb;
		logic [2:0][DW-1:0] u;
		logic [2:0][DW-1:0] v;
	} geo_t;

	typedef struct packed {
		logic signed [XW-1:0] det;
		logic signed [XW-1:0] sn;
		logic signed [XW-1:0] tn;
		logic signed [PW-1:0] a;
		logic signed [PW-1:0] c;
		logic signed [PW-1:0] e;
		logic signed [PW-1:0] eb;
		logic signed [PW-1:0] nd;
		logic signed [PW-1:0] bd;
	} dots_t;

	typedef struct packed {
		logic [FW-1:0] sn;
		logic [FW-1:0] sd;
		logic [FW-1:0] tn;
		logic [FW-1:0] td;
	} frac_t;

	typedef struct packed {
		logic [LANES-1:0][CW-1:0] pt;    // a x,y,z then b x,y,z
	} near_t;

	function automatic logic signed [XW-1:0] xext(input logic signed [PW-1:0] x);
		return XW'(x);
	endfunction

endpackage

// ----- rtl/core/sgca_dot.sv -----
// ----------------------------------------------------------------------------
// sgca_dot
// Edge vectors, dot products, determinant and raw parameter numerators.
// ----------------------------------------------------------------------------
module sgca_dot
	import sgca_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [NPTS-1:0][CW-1:0]  pts,
	output logic                     out_vld,
	output geo_t                     geo,
	output dots_t                    dots
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	geo_t geo_in, geo_s1, geo_s2, geo_s3, geo_s4;
	logic [2:0][DW-1:0] w_in, w_s1;
	logic signed [PW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2;
	logic signed [PW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [XW-1:0] ac_s3, bb_s3, be_s3, cd_s3, ae_s3, bd_s3;
	dots_t dots_s4;

	function automatic logic [DW-1:0] dext(input logic [CW-1:0] x);
		return DW'($signed(x));
	endfunction

	function automatic logic signed [PW-1:0] dot3(input logic [2:0][DW-1:0] x,
			input logic [2:0][DW-1:0] y);
		logic signed [PW-1:0] s;
		logic signed [PW-1:0] xe;
		logic signed [PW-1:0] ye;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			xe = PW'($signed(x[k]));
			ye = PW'($signed(y[k]));
			s  = s + xe * ye;
		end
		return s;
	endfunction

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			geo_in.pa[k] = pts[k];
			geo_in.pb[k] = pts[6+k];
			geo_in.u[k]  = dext(pts[3+k]) - dext(pts[k]);
			geo_in.v[k]  = dext(pts[9+k]) - dext(pts[6+k]);
			w_in[k]      = dext(pts[k]) - dext(pts[6+k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1 <= geo_in;
			w_s1   <= w_in;

			geo_s2 <= geo_s1;
			a_s2   <= dot3(geo_s1.u, geo_s1.u);
			b_s2   <= dot3(geo_s1.u, geo_s1.v);
			c_s2   <= dot3(geo_s1.v, geo_s1.v);
			d_s2   <= dot3(geo_s1.u, w_s1);
			e_s2   <= dot3(geo_s1.v, w_s1);

			geo_s3 <= geo_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
			e_s3   <= e_s2;
			ac_s3  <= xext(a_s2) * xext(c_s2);
			bb_s3  <= xext(b_s2) * xext(b_s2);
			be_s3  <= xext(b_s2) * xext(e_s2);
			cd_s3  <= xext(c_s2) * xext(d_s2);
			ae_s3  <= xext(a_s2) * xext(e_s2);
			bd_s3  <= xext(b_s2) * xext(d_s2);

			geo_s4      <= geo_s3;
			dots_s4.det <= ac_s3 - bb_s3;
			dots_s4.sn  <= be_s3 - cd_s3;
			dots_s4.tn  <= ae_s3 - bd_s3;
			dots_s4.a   <= a_s3;
			dots_s4.c   <= c_s3;
			dots_s4.e   <= e_s3;
			dots_s4.eb  <= e_s3 + b_s3;
			dots_s4.nd  <= -d_s3;
			dots_s4.bd  <= b_s3 - d_s3;
		end
	end

	assign out_vld = vld_s4;
	assign geo     = geo_s4;
	assign dots    = dots_s4;

endmodule

// ----- rtl/core/sgca_clamp.sv -----
// ----------------------------------------------------------------------------
// sgca_clamp
// Parallel test and clamping of both segment parameters to [0,1].
// ----------------------------------------------------------------------------
module sgca_clamp
	import sgca_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [LW-1:0] limit,
	input  logic          in_vld,
	input  geo_t          geo_in,
	input  dots_t         dots,
	output logic          out_vld,
	output geo_t          geo,
	output frac_t         frac
);

	logic vld_s5, vld_s6;
	geo_t geo_s5, geo_s6;
	logic signed [XW-1:0] sn_s5, sd_s5, tn_s5, td_s5;
	logic signed [PW-1:0] a_s5, nd_s5, bd_s5;
	logic signed [XW-1:0] sn5, sd5, tn5, td5;
	logic signed [XW-1:0] sn6, sd6, tn6, m6;
	frac_t frac_s6;
	logic par;

	always_comb begin
		par = dots.det < XW'($signed({1'b0, limit}));
		sn5 = dots.sn;
		sd5 = dots.det;
		tn5 = dots.tn;
		td5 = dots.det;
		if (par) begin
			sn5 = '0;
			sd5 = XW'(1);
			tn5 = xext(dots.e);
			td5 = xext(dots.c);
		end else if (dots.sn[XW-1]) begin
			sn5 = '0;
			tn5 = xext(dots.e);
			td5 = xext(dots.c);
		end else if (dots.sn > dots.det) begin
			sn5 = dots.det;
			tn5 = xext(dots.eb);
			td5 = xext(dots.c);
		end
	end

	always_comb begin
		sn6 = sn_s5;
		sd6 = sd_s5;
		tn6 = tn_s5;
		m6  = xext(bd_s5);
		if (tn_s5[XW-1] || tn_s5 > td_s5) begin
			if (tn_s5[XW-1]) begin
				tn6 = '0;
				m6  = xext(nd_s5);
			end else begin
				tn6 = td_s5;
			end
			priority if (m6[XW-1]) begin
				sn6 = '0;
			end else if (m6 > xext(a_s5)) begin
				sn6 = sd_s5;
			end else begin
				sn6 = m6;
				sd6 = xext(a_s5);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= in_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5     <= geo_in;
			sn_s5      <= sn5;
			sd_s5      <= sd5;
			tn_s5      <= tn5;
			td_s5      <= td5;
			a_s5       <= dots.a;
			nd_s5      <= dots.nd;
			bd_s5      <= dots.bd;
			geo_s6     <= geo_s5;
			frac_s6.sn <= sn6[FW-1:0];
			frac_s6.sd <= sd6[FW-1:0];
			frac_s6.tn <= tn6[FW-1:0];
			frac_s6.td <= td_s5[FW-1:0];
		end
	end

	assign out_vld = vld_s6;
	assign geo     = geo_s6;
	assign frac    = frac_s6;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> frac_s6.sn <= frac_s6.sd)
		else $error("segment A parameter above one");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> frac_s6.tn <= frac_s6.td)
		else $error("segment B parameter above one");
`endif

endmodule

// ----- rtl/core/sgca_scale.sv -----
// ----------------------------------------------------------------------------
// sgca_scale
// Bit-per-stage division scaling each edge component by its clamped fraction,
// then rounding, offset by the start point and saturation.
// ----------------------------------------------------------------------------
module sgca_scale
	import sgca_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  geo_t  geo,
	input  frac_t frac,
	output logic  out_vld,
	output near_t near
);

	localparam int DIVN = DW - 1;
	localparam int DBW  = $clog2(DIVN);
	localparam int SVW  = CW + 3;
	localparam logic signed [SVW-1:0] CMAX = SVW'((2 ** (CW - 1)) - 1);
	localparam logic signed [SVW-1:0] CMIN = ~CMAX;

	typedef struct packed {
		logic [FW-1:0] sn;
		logic [FW-1:0] sd;
		logic [FW-1:0] tn;
		logic [FW-1:0] td;
		logic [LANES-1:0][DW-2:0] mag;
		logic [LANES-1:0] neg;
		logic [LANES-1:0][CW-1:0] base;
		logic [LANES-1:0][FW-1:0] rem;
		logic [LANES-1:0][QW-1:0] quo;
	} div_t;

	div_t dv_in;
	div_t dv_nx [DIVN];
	div_t dv_s  [DIVN];
	logic [DIVN-1:0] vld_s;
	logic vld_sf;
	near_t near_sf, near_nx;

	function automatic div_t div_step(input div_t s, input logic [DBW-1:0] b);
		div_t r;
		logic [FW+1:0] acc;
		logic [FW+1:0] num;
		logic [FW+1:0] den;
		logic [1:0] dig;
		r = s;
		for (int k = 0; k < LANES; k++) begin
			num = (k < 3) ? {2'b00, s.sn} : {2'b00, s.tn};
			den = (k < 3) ? {2'b00, s.sd} : {2'b00, s.td};
			acc = {1'b0, s.rem[k], 1'b0} + (s.mag[k][b] ? num : '0);
			dig = 2'd0;
			if (acc >= {den[FW:0], 1'b0}) begin
				acc = acc - {den[FW:0], 1'b0};
				dig = 2'd2;
			end else if (acc >= den) begin
				acc = acc - den;
				dig = 2'd1;
			end
			r.rem[k] = acc[FW-1:0];
			r.quo[k] = {s.quo[k][QW-2:0], 1'b0} + QW'(dig);
		end
		return r;
	endfunction

	always_comb begin
		logic [DW-1:0] comp;
		dv_in.sn = frac.sn;
		dv_in.sd = frac.sd;
		dv_in.tn = frac.tn;
		dv_in.td = frac.td;
		for (int k = 0; k < LANES; k++) begin
			comp = (k < 3) ? geo.u[k % 3] : geo.v[k % 3];
			dv_in.neg[k]  = comp[DW-1];
			comp          = comp[DW-1] ? (DW'(0) - comp) : comp;
			dv_in.mag[k]  = comp[DW-2:0];
			dv_in.base[k] = (k < 3) ? geo.pa[k % 3] : geo.pb[k % 3];
			dv_in.rem[k]  = '0;
			dv_in.quo[k]  = '0;
		end
	end

	always_comb begin
		dv_nx[0] = div_step(dv_in, DBW'(DIVN - 1));
		for (int i = 1; i < DIVN; i++) begin
			dv_nx[i] = div_step(dv_s[i-1], DBW'(DIVN - 1 - i));
		end
	end

	always_comb begin
		logic [FW-1:0] den;
		logic [QW-1:0] q;
		logic signed [SVW-1:0] val;
		logic signed [SVW-1:0] qe;
		for (int k = 0; k < LANES; k++) begin
			den = (k < 3) ? dv_s[DIVN-1].sd : dv_s[DIVN-1].td;
			q   = dv_s[DIVN-1].quo[k]
				+ QW'({1'b0, dv_s[DIVN-1].rem[k], 1'b0} >= {2'b00, den});
			if (den == '0) begin
				q = '0;
			end
			qe  = SVW'(q);
			val = SVW'($signed(dv_s[DIVN-1].base[k]));
			val = dv_s[DIVN-1].neg[k] ? (val - qe) : (val + qe);
			if (val > CMAX) begin
				val = CMAX;
			end else if (val < CMIN) begin
				val = CMIN;
			end
			near_nx.pt[k] = val[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_s  <= {vld_s[DIVN-2:0], in_vld};
			vld_sf <= vld_s[DIVN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIVN; i++) begin
				dv_s[i] <= dv_nx[i];
			end
			near_sf <= near_nx;
		end
	end

	assign out_vld = vld_sf;
	assign near    = near_sf;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIVN-1] |->
			(dv_s[DIVN-1].sd == '0 || dv_s[DIVN-1].rem[0] < dv_s[DIVN-1].sd) &&
			(dv_s[DIVN-1].td == '0 || dv_s[DIVN-1].rem[3] < dv_s[DIVN-1].td))
		else $error("division remainder not below divisor");
`endif

endmodule

// ----- rtl/core/sgca_gap.sv -----
// ----------------------------------------------------------------------------
// sgca_gap
// Squared distance of the near points and a pipelined rounded square root.
// ----------------------------------------------------------------------------
module sgca_gap
	import sgca_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  near_t         near_in,
	output logic          out_vld,
	output logic [GW-1:0] gap,
	output near_t         near
);

	localparam int SQN = GW;

	typedef struct packed {
		logic [SW-1:0] x;
		logic [SW-1:0] res;
		near_t pts;
	} sq_t;

	logic vld_s1, vld_s3;
	logic [SQN-1:0] vld_s2;
	sq_t sq_in;
	sq_t sq_s1;
	sq_t sq_nx [SQN];
	sq_t sq_s2 [SQN];
	logic [GW-1:0] gap_s3;
	near_t near_s3;
	logic [SW-1:0] sum;
	logic [GW-1:0] gap_nx;

	function automatic sq_t sq_step(input sq_t s, input int unsigned i);
		sq_t r;
		logic [SW-1:0] bits;
		logic [SW:0] trial;
		r     = s;
		bits  = SW'(1) << (2 * (SQN - 1 - i));
		trial = {1'b0, s.res} + {1'b0, bits};
		if ({1'b0, s.x} >= trial) begin
			r.x   = s.x - trial[SW-1:0];
			r.res = (s.res >> 1) + bits;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	always_comb begin
		logic [DW-1:0] df;
		logic [DW-2:0] ad;
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			df  = DW'($signed(near_in.pt[k])) - DW'($signed(near_in.pt[3+k]));
			df  = df[DW-1] ? (DW'(0) - df) : df;
			ad  = df[DW-2:0];
			sum = sum + SW'(ad) * SW'(ad);
		end
		sq_in.x   = sum;
		sq_in.res = '0;
		sq_in.pts = near_in;
	end

	always_comb begin
		sq_nx[0] = sq_step(sq_s1, 0);
		for (int i = 1; i < SQN; i++) begin
			sq_nx[i] = sq_step(sq_s2[i-1], i);
		end
		gap_nx = (sq_s2[SQN-1].x > sq_s2[SQN-1].res)
			? GW'(sq_s2[SQN-1].res + SW'(1)) : GW'(sq_s2[SQN-1].res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= '0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= {vld_s2[SQN-2:0], vld_s1};
			vld_s3 <= vld_s2[SQN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= sq_in;
			for (int i = 0; i < SQN; i++) begin
				sq_s2[i] <= sq_nx[i];
			end
			gap_s3  <= gap_nx;
			near_s3 <= sq_s2[SQN-1].pts;
		end
	end

	assign out_vld = vld_s3;
	assign gap     = gap_s3;
	assign near    = near_s3;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2[SQN-1] |-> {1'b0, sq_s2[SQN-1].x} <= {sq_s2[SQN-1].res, 1'b0})
		else $error("square root remainder too large");
`endif

endmodule

// ----- rtl/core/segment_pair_closest_approach.sv -----
// ----------------------------------------------------------------------------
// segment_pair_closest_approach
// Closest points of two 3D segments and the distance between them.
// ----------------------------------------------------------------------------
// Fully pipelined: one segment pair is taken per clock unless a stall holds
// the pipe, and its result passes through 4 dot product stages, 2 clamp
// stages, 17 division stages and 19 distance and square root stages. The
// depth is set by the one quotient bit per stage divider and the one root
// bit per stage square root. A waiting result with m_tready low freezes
// every stage together; s_tready is that same stage enable.
module segment_pair_closest_approach
	import sgca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             parallel_limit_we,
	input  logic [LW-1:0]    parallel_limit_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// a_start x,y,z, a_end x,y,z, b_start x,y,z, b_end x,y,z
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// gap_length, near_a x,y,z, near_b x,y,z, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	logic en;
	logic [LW-1:0] limit_q;
	logic [NPTS-1:0][CW-1:0] pts;
	logic dot_vld, clamp_vld, scale_vld;
	geo_t dot_geo, clamp_geo;
	dots_t dots;
	frac_t frac;
	near_t scale_near, out_near;
	logic [GW-1:0] gap;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign pts      = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LW'(1);
		end else if (parallel_limit_we) begin
			limit_q <= parallel_limit_wdata;
		end
	end

	sgca_dot u_dot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.pts     (pts),
		.out_vld (dot_vld),
		.geo     (dot_geo),
		.dots    (dots)
	);

	sgca_clamp u_clamp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.limit   (limit_q),
		.in_vld  (dot_vld),
		.geo_in  (dot_geo),
		.dots    (dots),
		.out_vld (clamp_vld),
		.geo     (clamp_geo),
		.frac    (frac)
	);

	sgca_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (clamp_vld),
		.geo     (clamp_geo),
		.frac    (frac),
		.out_vld (scale_vld),
		.near    (scale_near)
	);

	sgca_gap u_gap (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (scale_vld),
		.near_in (scale_near),
		.out_vld (m_tvalid),
		.gap     (gap),
		.near    (out_near)
	);

	assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, out_near.pt, gap};

endmodule
